// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the modular exponentiation RTL.
// Needs nothing else; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset
`define MEXP_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mexp assertion failed");

// Next-cycle implication, disabled while in reset
`define MEXP_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mexp assertion failed");

`endif

// ----- rtl/mexp_pkg.sv -----
// Package for the modular exponentiation block: widths, constants and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package mexp_pkg;

    localparam int unsigned EXP_BITS        = 64;
    localparam int unsigned MOD_BITS        = 32;
    localparam int unsigned BASE_BITS       = 63;
    localparam int unsigned EXPO_FIELD_BITS = 63;
    localparam int unsigned CNT_BITS        = 6;

    localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(1000000007);

    // last step of the base reduction and of one modular multiply
    localparam logic [CNT_BITS-1:0] RED_LAST = CNT_BITS'(BASE_BITS - 1);
    localparam logic [CNT_BITS-1:0] MUL_LAST = CNT_BITS'(MOD_BITS - 1);

    typedef struct packed {
        logic load;      // capture request, start base reduction
        logic red_step;  // one base-reduction bit
        logic dbl_step;  // double both partial products
        logic add_step;  // conditional add into both partial products
        logic commit;    // b <= square, reload multiplier, clear partials
        logic step_e;    // take product into acc if bit set, shift exponent
        logic out_load;  // load the result register
    } mexp_cmd_t;

    typedef struct packed {
        logic e_zero;    // no exponent bits left
        logic e_last;    // only bit 0 of the exponent may remain
    } mexp_sts_t;

endpackage

// ----- rtl/mexp_req_if.sv -----
// Request channel: valid/ready plus op, base and exponent.
// Depends on mexp_pkg for the field widths.
`timescale 1ns / 1ps

interface mexp_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 op;
    logic [mexp_pkg::BASE_BITS-1:0]       base;
    logic [mexp_pkg::EXPO_FIELD_BITS-1:0] exponent;

    modport source (output valid, op, base, exponent, input ready);
    modport sink   (input valid, op, base, exponent, output ready);
endinterface

// ----- rtl/mexp_res_if.sv -----
// Result channel: valid/ready plus the reduced power.
// Depends on mexp_pkg for the field width.
`timescale 1ns / 1ps

interface mexp_res_if;
    logic                          valid;
    logic                          ready;
    logic [mexp_pkg::MOD_BITS-1:0] result;

    modport source (output valid, result, input ready);
    modport sink   (input valid, result, output ready);
endinterface

// ----- rtl/modular_exponentiation.sv -----
// Channel  Dir  Handshake     Payload
// req      in   valid/ready   op, base[62:0], exponent[62:0]
// res      out  valid/ready   result[31:0]
// cfg      in   cfg_we        cfg_wdata[31:0] -> modulus
//
// One request at a time: base reduction one base bit at a time, a setup step,
// then one multiply round per exponent bit up to the highest set bit (two 32-step
// shift-add modular multipliers run side by side), then the result load once the
// output register is free. Exponent 0 goes from the setup step to the result load.
// Reset: asynchronous, active low; modulus returns to 1000000007.
// A finished result waits in the output register; req_ready returns once it loads.
`timescale 1ns / 1ps

module modular_exponentiation (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [mexp_pkg::MOD_BITS-1:0] cfg_wdata,
    mexp_req_if.sink                      req,
    mexp_res_if.source                    res
);

    mexp_pkg::mexp_cmd_t cmd;
    mexp_pkg::mexp_sts_t sts;

    // sequencing
    mexp_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .res_valid (res.valid),
        .res_ready (res.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // arithmetic
    mexp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .op        (req.op),
        .base      (req.base),
        .exponent  (req.exponent),
        .result    (res.result)
    );

endmodule

// ----- rtl/mexp_ctrl.sv -----
// Sequencing FSM for the modular exponentiation block: base reduction,
// shift-add multiply steps per exponent bit, result hand-off. Uses mexp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    output logic                res_valid,
    input  logic                res_ready,
    input  mexp_pkg::mexp_sts_t sts,
    output mexp_pkg::mexp_cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_REDUCE = 7'b0000010,
        ST_FIRST  = 7'b0000100,
        ST_DBL    = 7'b0001000,
        ST_ADD    = 7'b0010000,
        ST_COMMIT = 7'b0100000,
        ST_DONE   = 7'b1000000
    } mexp_state_t;

    mexp_state_t                     state_reg, state_next;
    logic [mexp_pkg::CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                            out_valid_reg, out_valid_next;

    // next state, step counter and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE:
            begin
                cmd.red_step = 1'b1;
                cnt_next     = cnt_reg + mexp_pkg::CNT_BITS'(1);
                if (cnt_reg == mexp_pkg::RED_LAST)
                    state_next = ST_FIRST;
            end
            ST_FIRST:
            begin
                cmd.commit = 1'b1;
                cnt_next   = '0;
                state_next = sts.e_zero ? ST_DONE : ST_DBL;
            end
            ST_DBL:
            begin
                cmd.dbl_step = 1'b1;
                state_next   = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_step = 1'b1;
                cnt_next     = cnt_reg + mexp_pkg::CNT_BITS'(1);
                state_next   = (cnt_reg == mexp_pkg::MUL_LAST) ? ST_COMMIT : ST_DBL;
            end
            ST_COMMIT:
            begin
                cmd.commit = 1'b1;
                cmd.step_e = 1'b1;
                cnt_next   = '0;
                state_next = sts.e_last ? ST_DONE : ST_DBL;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || res_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result valid: set on load, cleared when taken
    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = out_valid_reg;

    `MEXP_ASSERT_NXT(a_accept_reduce, clk, rst_n, req_valid && req_ready, state_reg == ST_REDUCE && cnt_reg == '0)
    `MEXP_ASSERT_NXT(a_dbl_then_add, clk, rst_n, state_reg == ST_DBL, state_reg == ST_ADD)
    `MEXP_ASSERT_NXT(a_mul_end, clk, rst_n, state_reg == ST_ADD && cnt_reg == mexp_pkg::MUL_LAST, state_reg == ST_COMMIT)

endmodule

// ----- rtl/mexp_dp.sv -----
// Datapath: modulus register, base reduction, two shift-add modular
// multipliers (acc*b and b*b) and the result register. Uses mexp_pkg.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_dp (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [mexp_pkg::MOD_BITS-1:0]        cfg_wdata,
    input  mexp_pkg::mexp_cmd_t                  cmd,
    output mexp_pkg::mexp_sts_t                  sts,
    input  logic                                 op,
    input  logic [mexp_pkg::BASE_BITS-1:0]       base,
    input  logic [mexp_pkg::EXPO_FIELD_BITS-1:0] exponent,
    output logic [mexp_pkg::MOD_BITS-1:0]        result
);

    localparam int unsigned MB = mexp_pkg::MOD_BITS;
    localparam int unsigned EB = mexp_pkg::EXP_BITS;

    logic [MB-1:0]                  m_reg;
    logic [MB-1:0]                  acc_reg, b_reg, pa_reg, pb_reg, y_reg, result_reg;
    logic [EB-1:0]                  e_reg;
    logic [mexp_pkg::BASE_BITS-1:0] base_sh_reg;

    logic [EB-1:0] e_init;
    logic [MB-1:0] acc_init;
    logic [MB-1:0] pa_opb, pb_opb, pa_sum, pb_sum;
    logic          pb_cin;

    // a + b + cin reduced once; valid while a, b < m
    function automatic logic [MB-1:0] add_mod(input logic [MB-1:0] a,
                                              input logic [MB-1:0] b,
                                              input logic          cin,
                                              input logic [MB-1:0] m);
        logic [MB:0] s;
        s = {1'b0, a} + {1'b0, b} + {{MB{1'b0}}, cin};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return s[MB-1:0];
    endfunction

    // modulus register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_reg <= mexp_pkg::MODULUS_RESET;
        else if (cfg_we)
            m_reg <= cfg_wdata;
    end

    // exponent and accumulator start values
    always_comb
    begin
        if (op)
            e_init = (m_reg >= MB'(2)) ? EB'(m_reg - MB'(2)) : '0;
        else
            e_init = EB'(exponent);
        acc_init = (m_reg == MB'(1)) ? '0 : MB'(1);
    end

    // shared modular adders: doubling, conditional add, reduction step
    always_comb
    begin
        pa_opb = cmd.add_step ? acc_reg : pa_reg;
        pb_opb = cmd.add_step ? b_reg : pb_reg;
        pb_cin = cmd.red_step & base_sh_reg[mexp_pkg::BASE_BITS-1];
        pa_sum = add_mod(pa_reg, pa_opb, 1'b0, m_reg);
        pb_sum = add_mod(pb_reg, pb_opb, pb_cin, m_reg);
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            base_sh_reg <= base;
            e_reg       <= e_init;
            acc_reg     <= acc_init;
            pb_reg      <= '0;
        end
        else
        begin
            if (cmd.red_step)
                base_sh_reg <= {base_sh_reg[mexp_pkg::BASE_BITS-2:0], 1'b0};

            if (cmd.commit)
            begin
                b_reg  <= pb_reg;
                y_reg  <= pb_reg;
                pa_reg <= '0;
                pb_reg <= '0;
            end
            else if (cmd.red_step || cmd.dbl_step || (cmd.add_step && y_reg[MB-1]))
            begin
                pa_reg <= pa_sum;
                pb_reg <= pb_sum;
            end

            if (cmd.add_step)
                y_reg <= {y_reg[MB-2:0], 1'b0};

            if (cmd.step_e)
            begin
                if (e_reg[0])
                    acc_reg <= pa_reg;
                e_reg <= {1'b0, e_reg[EB-1:1]};
            end
        end

        if (cmd.out_load)
            result_reg <= (m_reg == '0) ? '0 : acc_reg;
    end

    assign sts.e_zero = (e_reg == '0);
    assign sts.e_last = (e_reg[EB-1:1] == '0);
    assign result     = result_reg;

    `MEXP_ASSERT_NXT(a_mult_reload, clk, rst_n, cmd.commit, y_reg == b_reg && pa_reg == '0)

endmodule
